### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/fjdr_pkg.sv
// ---------------------------------------------------------------------------
// fjdr_pkg
// Types, register indexes and reset values for the feeder jam detector.
// ---------------------------------------------------------------------------
package fjdr_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_POS_ERR_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_SPD_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_TICK_LIM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETREAT_DIST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_TOL     = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_POS_ERR_LIMIT   = 16'd6;
	localparam logic [14:0] RST_STALL_SPD_LIMIT = 15'd10;
	localparam logic [15:0] RST_STALL_TICK_LIM  = 16'd100;
	localparam logic [15:0] RST_RETREAT_DIST    = 16'd34;
	localparam logic [15:0] RST_ARRIVAL_TOL     = 16'd40;

	localparam int unsigned IN_TDATA_W   = 96;
	localparam int unsigned OUT_TDATA_W  = 56;
	localparam int unsigned OUT_TUSER_W  = 2;

	// Recovery sequencer states
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_LATCH   = 2'd1,
		PH_RETREAT = 2'd2,
		PH_FINISH  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] position_error_limit;
		logic [14:0] stall_speed_limit;
		logic [15:0] stall_tick_limit;
		logic [15:0] retreat_distance;
		logic [15:0] arrival_tolerance;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] target_position;
		logic signed [31:0] feedback_position;
		logic signed [15:0] feedback_speed;
		logic [15:0]        feedback_shot_count;
	} item_t;

	typedef struct packed {
		logic               override_valid;
		logic signed [31:0] target_override;
		logic               jam_active;
		logic               reload_valid;
		logic [15:0]        reload_shot_count;
	} result_t;

endpackage

### rtl/fjdr_cfg_regs.sv
// ---------------------------------------------------------------------------
// fjdr_cfg_regs
// Threshold and distance registers, written through the configuration port.
// ---------------------------------------------------------------------------
module fjdr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fjdr_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [15:0]                      wr_data,
	output fjdr_pkg::cfg_t                   cfg
);

	fjdr_pkg::cfg_t cfg_q;

	// Register file; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_error_limit <= fjdr_pkg::RST_POS_ERR_LIMIT;
			cfg_q.stall_speed_limit    <= fjdr_pkg::RST_STALL_SPD_LIMIT;
			cfg_q.stall_tick_limit     <= fjdr_pkg::RST_STALL_TICK_LIM;
			cfg_q.retreat_distance     <= fjdr_pkg::RST_RETREAT_DIST;
			cfg_q.arrival_tolerance    <= fjdr_pkg::RST_ARRIVAL_TOL;
		end else if (wr_en) begin
			case (wr_index)
				fjdr_pkg::REG_POS_ERR_LIMIT:   cfg_q.position_error_limit <= wr_data;
				fjdr_pkg::REG_STALL_SPD_LIMIT: cfg_q.stall_speed_limit    <= wr_data[14:0];
				fjdr_pkg::REG_STALL_TICK_LIM:  cfg_q.stall_tick_limit     <= wr_data;
				fjdr_pkg::REG_RETREAT_DIST:    cfg_q.retreat_distance     <= wr_data;
				fjdr_pkg::REG_ARRIVAL_TOL:     cfg_q.arrival_tolerance    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/fjdr_jam_ctrl.sv
// ---------------------------------------------------------------------------
// fjdr_jam_ctrl
// Stall counter, jam flag and retreat sequencer; one tick per enable.
// ---------------------------------------------------------------------------
module fjdr_jam_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  fjdr_pkg::item_t     item,
	input  fjdr_pkg::cfg_t      cfg,
	output fjdr_pkg::result_t   res
);

	logic [15:0]        stall_ticks_q;
	logic               jam_q;
	fjdr_pkg::phase_t   phase_q;
	logic signed [31:0] retreat_q;

	logic [32:0]        err_d;
	logic [32:0]        err_mag;
	logic [16:0]        spd_mag;
	logic [32:0]        arr_d;
	logic [32:0]        arr_mag;
	logic               stalled;
	logic               arrived;
	logic [15:0]        stall_inc;
	logic               set_jam;
	logic               jam_eff;
	fjdr_pkg::phase_t   phase_eff;
	logic [31:0]        latch_target;

	logic [15:0]        stall_ticks_d;
	logic               jam_d;
	fjdr_pkg::phase_t   phase_d;
	logic signed [31:0] retreat_d;

	// Exact 33-bit error and arrival distances, 17-bit speed magnitude
	always_comb begin
		err_d   = {item.target_position[31], item.target_position}
		        - {item.feedback_position[31], item.feedback_position};
		err_mag = err_d[32] ? (33'd0 - err_d) : err_d;
		spd_mag = item.feedback_speed[15] ? (17'd0 - {1'b1, item.feedback_speed})
		                                  : {1'b0, item.feedback_speed};
		arr_d   = {item.feedback_position[31], item.feedback_position}
		        - {retreat_q[31], retreat_q};
		arr_mag = arr_d[32] ? (33'd0 - arr_d) : arr_d;
		stalled = (err_mag > {17'd0, cfg.position_error_limit})
		       && (spd_mag < {2'd0, cfg.stall_speed_limit});
		arrived = arr_mag < {17'd0, cfg.arrival_tolerance};
		latch_target = item.feedback_position - {16'd0, cfg.retreat_distance};
	end

	// Saturating stall counter and jam detection
	always_comb begin
		stall_inc = (stall_ticks_q == 16'hFFFF) ? stall_ticks_q : stall_ticks_q + 16'd1;
		stall_ticks_d = stalled ? stall_inc : 16'd0;
		set_jam   = (stall_ticks_d > cfg.stall_tick_limit) && !jam_q;
		jam_eff   = jam_q | set_jam;
		phase_eff = set_jam ? fjdr_pkg::PH_LATCH : phase_q;
	end

	// Next state of the recovery sequencer
	always_comb begin
		jam_d     = jam_eff;
		phase_d   = phase_eff;
		retreat_d = retreat_q;
		if (jam_eff) begin
			case (phase_eff)
				fjdr_pkg::PH_LATCH: begin
					retreat_d = latch_target;
					phase_d   = fjdr_pkg::PH_RETREAT;
				end
				fjdr_pkg::PH_RETREAT: begin
					if (arrived) begin
						phase_d = fjdr_pkg::PH_FINISH;
					end
				end
				fjdr_pkg::PH_FINISH: begin
					jam_d   = 1'b0;
					phase_d = fjdr_pkg::PH_IDLE;
				end
				default: ;
			endcase
		end
	end

	// Result of this tick
	always_comb begin
		res.override_valid    = 1'b0;
		res.target_override   = 32'sd0;
		res.jam_active        = jam_d;
		res.reload_valid      = 1'b0;
		res.reload_shot_count = 16'd0;
		if (jam_eff) begin
			case (phase_eff)
				fjdr_pkg::PH_LATCH: begin
					res.override_valid  = 1'b1;
					res.target_override = latch_target;
				end
				fjdr_pkg::PH_RETREAT: begin
					res.override_valid  = 1'b1;
					res.target_override = retreat_q;
				end
				fjdr_pkg::PH_FINISH: begin
					res.reload_valid      = 1'b1;
					res.reload_shot_count = item.feedback_shot_count;
				end
				default: ;
			endcase
		end
	end

	// State registers; finishing recovery also clears the counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_ticks_q <= 16'd0;
			jam_q         <= 1'b0;
			phase_q       <= fjdr_pkg::PH_IDLE;
			retreat_q     <= 32'sd0;
		end else if (tick) begin
			stall_ticks_q <= (jam_eff && phase_eff == fjdr_pkg::PH_FINISH) ? 16'd0
			                                                                : stall_ticks_d;
			jam_q         <= jam_d;
			phase_q       <= phase_d;
			retreat_q     <= retreat_d;
		end
	end

endmodule

### rtl/feeder_jam_detect_retreat_core.sv
// ---------------------------------------------------------------------------
// feeder_jam_detect_retreat_core
// Feeder jam detector with position-retreat recovery, one tick per transaction.
// ---------------------------------------------------------------------------
// Each slave transaction is one control tick and yields exactly one master
// transaction. A tick passes an input register, is evaluated by the jam
// controller combinationally and lands in the result register, and a new
// tick is taken every cycle while the result side keeps up; the single
// result register stalls the input only when it is full and not being
// taken. Configuration writes are accepted every cycle and should be made
// while no tick is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module feeder_jam_detect_retreat_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fjdr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [15:0]                           cfg_data,
	// Tick input
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// target_position[31:0], feedback_position[63:32],
	// feedback_speed[79:64], feedback_shot_count[95:80]
	input  logic [fjdr_pkg::IN_TDATA_W-1:0]       s_tdata,
	// Tick result
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// target_override[31:0], jam_active[32], reload_shot_count[48:33], zero[55:49]
	output logic [fjdr_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// override_valid[0], reload_valid[1]
	output logic [fjdr_pkg::OUT_TUSER_W-1:0]      m_tuser
);

	fjdr_pkg::cfg_t    cfg;
	fjdr_pkg::item_t   item_s1;
	logic              valid_s1;
	fjdr_pkg::result_t res_d;
	fjdr_pkg::result_t res_q;
	logic              out_valid_q;
	logic              adv;

	// Configuration registers
	assign cfg_ready = 1'b1;

	fjdr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: item moves on when the result register is free or drains
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.target_position     <= s_tdata[31:0];
			item_s1.feedback_position   <= s_tdata[63:32];
			item_s1.feedback_speed      <= s_tdata[79:64];
			item_s1.feedback_shot_count <= s_tdata[95:80];
		end
	end

	// Jam controller
	fjdr_jam_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, res_q.reload_shot_count, res_q.jam_active, res_q.target_override};
	assign m_tuser  = {res_q.reload_valid, res_q.override_valid};

	// Checks
	`ASSERT_NEVER(a_ov_rl_excl, clk, arst_n, out_valid_q && res_q.override_valid && res_q.reload_valid, "override and reload in one result")
	`ASSERT_AR(a_ov_jam, clk, arst_n, (out_valid_q && res_q.override_valid) |-> res_q.jam_active, "override without jam flag")
	`ASSERT_AR(a_rl_clr, clk, arst_n, (out_valid_q && res_q.reload_valid) |-> !res_q.jam_active, "reload with jam flag still set")
	`ASSERT_AR(a_stall_cause, clk, arst_n, !s_tready |-> (valid_s1 && out_valid_q && !m_tready), "input stalled with room")

endmodule

### dv/tb_feeder_jam_detect_retreat_core.sv
// ---------------------------------------------------------------------------
// tb_feeder_jam_detect_retreat_core
// Self-checking bench for the feeder jam detector with retreat recovery.
// ---------------------------------------------------------------------------
// A directed table walks the field extremes, both speed limits, the stall
// counter and a full jam episode with retreat wrap, no-arrival and arrival
// cases. Random phases follow, each with its own register settings. Most
// random ticks either build up a stall or steer the feedback toward the
// latched retreat target, and the rest are noise. An in-bench tick model
// predicts the result of every tick that has no expected result in the
// table, and the monitor compares each result transaction field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feeder_jam_detect_retreat_core;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned TICKS_PER_PHASE = 66;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [fjdr_pkg::CFG_IDX_W-1:0] idx;
		logic [15:0]                    val;
		fjdr_pkg::item_t                it;
		bit                             typed;
		fjdr_pkg::result_t              res;
	} dir_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [fjdr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [15:0]                      cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [fjdr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [fjdr_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [fjdr_pkg::OUT_TUSER_W-1:0] m_tuser;

	// Tick model state and register shadow
	fjdr_pkg::cfg_t     cfg_shadow;
	logic [15:0]        stall_cnt;
	logic               jam_flag;
	fjdr_pkg::phase_t   rec_phase;
	logic signed [31:0] retreat_pos;

	fjdr_pkg::result_t exp_results[$];
	dir_row_t          dir_rows[$];
	int unsigned       errors = 0;
	int unsigned       idle_cycles = 0;
	int unsigned       burst_left = 0;
	bit                tx_gappy = 1'b0;
	int unsigned       rx_mode = 0;
	logic [15:0]       rx_pat = 16'h00FF;

	feeder_jam_detect_retreat_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One control tick of the jam detector; updates the model state
	function automatic fjdr_pkg::result_t predict_tick(fjdr_pkg::item_t it);
		fjdr_pkg::result_t r;
		longint  pos_err;
		longint  spd_mag;
		longint  arr_err;
		r = '0;
		pos_err = longint'($signed(it.target_position)) - longint'($signed(it.feedback_position));
		if (pos_err < 0) pos_err = -pos_err;
		spd_mag = longint'($signed(it.feedback_speed));
		if (spd_mag < 0) spd_mag = -spd_mag;

		if (pos_err > longint'(cfg_shadow.position_error_limit) &&
		    spd_mag < longint'(cfg_shadow.stall_speed_limit)) begin
			if (stall_cnt != 16'hFFFF) stall_cnt = stall_cnt + 16'd1;
		end else begin
			stall_cnt = '0;
		end

		if (stall_cnt > cfg_shadow.stall_tick_limit && !jam_flag) begin
			jam_flag = 1'b1;
			rec_phase = fjdr_pkg::PH_LATCH;
		end

		if (jam_flag) begin
			case (rec_phase)
				fjdr_pkg::PH_LATCH: begin
					retreat_pos = it.feedback_position - {16'h0, cfg_shadow.retreat_distance};
					r.override_valid = 1'b1;
					r.target_override = retreat_pos;
					rec_phase = fjdr_pkg::PH_RETREAT;
				end
				fjdr_pkg::PH_RETREAT: begin
					r.override_valid = 1'b1;
					r.target_override = retreat_pos;
					arr_err = longint'($signed(it.feedback_position)) - longint'(retreat_pos);
					if (arr_err < 0) arr_err = -arr_err;
					if (arr_err < longint'(cfg_shadow.arrival_tolerance))
						rec_phase = fjdr_pkg::PH_FINISH;
				end
				fjdr_pkg::PH_FINISH: begin
					jam_flag = 1'b0;
					rec_phase = fjdr_pkg::PH_IDLE;
					stall_cnt = '0;
					r.reload_valid = 1'b1;
					r.reload_shot_count = it.feedback_shot_count;
				end
				default: ;
			endcase
		end
		r.jam_active = jam_flag;
		return r;
	endfunction

	// Random tick shaped by the model state: steer toward the retreat target
	// in the retreat phase, otherwise mostly build up a stall
	function automatic fjdr_pkg::item_t gen_tick();
		fjdr_pkg::item_t it;
		logic [31:0] base;
		int unsigned tol;
		int unsigned off;
		int unsigned spd_mag;
		it.target_position = $urandom;
		it.feedback_position = $urandom;
		it.feedback_speed = 16'($urandom);
		it.feedback_shot_count = 16'($urandom);
		if (jam_flag && rec_phase == fjdr_pkg::PH_RETREAT) begin
			tol = 32'(cfg_shadow.arrival_tolerance);
			case ($urandom_range(0, 2))
				0: if (tol != 0) begin
					off = $urandom_range(0, tol - 1);
					it.feedback_position = $urandom_range(0, 1) ? retreat_pos + off : retreat_pos - off;
				end
				// near miss around the tolerance edge
				1: begin
					off = tol + $urandom_range(0, 3);
					it.feedback_position = $urandom_range(0, 1) ? retreat_pos + off : retreat_pos - off;
				end
				default: ;
			endcase
		end else if ($urandom_range(0, 3) != 0) begin
			base = $urandom;
			off = 32'(cfg_shadow.position_error_limit) + $urandom_range(0, 300);
			it.feedback_position = base;
			it.target_position = $urandom_range(0, 1) ? base + off : base - off;
			if (cfg_shadow.stall_speed_limit != 0) begin
				spd_mag = $urandom_range(0, 32'(cfg_shadow.stall_speed_limit));
				it.feedback_speed = $urandom_range(0, 1) ? 16'(-spd_mag) : 16'(spd_mag);
			end
		end
		return it;
	endfunction

	function automatic dir_row_t tick_row(logic [31:0] tar, logic [31:0] fdb,
	                                      logic [15:0] spd, logic [15:0] shots);
		dir_row_t row;
		row.kind = ROW_TICK;
		row.idx = '0;
		row.val = '0;
		row.it = '{tar, fdb, spd, shots};
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic dir_row_t tick_exp(logic [31:0] tar, logic [31:0] fdb,
	                                      logic [15:0] spd, logic [15:0] shots,
	                                      fjdr_pkg::result_t res);
		dir_row_t row;
		row = tick_row(tar, fdb, spd, shots);
		row.typed = 1'b1;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(logic [fjdr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		dir_row_t row;
		row = tick_row('0, '0, '0, '0);
		row.kind = ROW_CFG;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	// Drive one tick transaction; valid stays high unless a gap follows
	task automatic send_tick(input fjdr_pkg::item_t it, input bit typed,
	                         input fjdr_pkg::result_t typed_res);
		fjdr_pkg::result_t pred;
		s_tvalid <= 1'b1;
		s_tdata <= {it.feedback_shot_count, it.feedback_speed,
		            it.feedback_position, it.target_position};
		do @(posedge clk); while (!s_tready);
		pred = predict_tick(it);
		exp_results.push_back(typed ? typed_res : pred);
		if (tx_gappy && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
	endtask

	// Register write transaction; caller drops cfg_valid after the last one
	task automatic write_reg(input logic [fjdr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fjdr_pkg::REG_POS_ERR_LIMIT:   cfg_shadow.position_error_limit = val;
			fjdr_pkg::REG_STALL_SPD_LIMIT: cfg_shadow.stall_speed_limit = val[14:0];
			fjdr_pkg::REG_STALL_TICK_LIM:  cfg_shadow.stall_tick_limit = val;
			fjdr_pkg::REG_RETREAT_DIST:    cfg_shadow.retreat_distance = val;
			fjdr_pkg::REG_ARRIVAL_TOL:     cfg_shadow.arrival_tolerance = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input fjdr_pkg::cfg_t c);
		wait_idle();
		write_reg(fjdr_pkg::REG_POS_ERR_LIMIT, c.position_error_limit);
		write_reg(fjdr_pkg::REG_STALL_SPD_LIMIT, {1'b0, c.stall_speed_limit});
		write_reg(fjdr_pkg::REG_STALL_TICK_LIM, c.stall_tick_limit);
		write_reg(fjdr_pkg::REG_RETREAT_DIST, c.retreat_distance);
		write_reg(fjdr_pkg::REG_ARRIVAL_TOL, c.arrival_tolerance);
		cfg_valid <= 1'b0;
		tx_gappy = $urandom_range(0, 3) != 0;
		rx_mode = $urandom_range(0, 2);
	endtask

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver: always ready, a rotating stall pattern, or coin flips
	always @(posedge clk) begin
		rx_pat <= {rx_pat[14:0], rx_pat[15]};
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= rx_pat[0];
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Result checker
	always @(posedge clk) begin : mon
		fjdr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_results.size() == 0) begin
				$display("%0t: unexpected result transaction, actual %h %h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = exp_results.pop_front();
				report_field("override_valid", 32'(want.override_valid), 32'(m_tuser[0]));
				report_field("target_override", want.target_override, m_tdata[31:0]);
				report_field("jam_active", 32'(want.jam_active), 32'(m_tdata[32]));
				report_field("reload_valid", 32'(want.reload_valid), 32'(m_tuser[1]));
				report_field("reload_shot_count", 32'(want.reload_shot_count), 32'(m_tdata[48:33]));
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		fjdr_pkg::cfg_t  c;
		fjdr_pkg::item_t it;
		cfg_shadow = '{fjdr_pkg::RST_POS_ERR_LIMIT, fjdr_pkg::RST_STALL_SPD_LIMIT,
		               fjdr_pkg::RST_STALL_TICK_LIM, fjdr_pkg::RST_RETREAT_DIST,
		               fjdr_pkg::RST_ARRIVAL_TOL};
		stall_cnt = '0;
		jam_flag = 1'b0;
		rec_phase = fjdr_pkg::PH_IDLE;
		retreat_pos = '0;

		// Directed table; registers start at their reset values
		dir_rows.push_back(tick_exp(32'h0, 32'h0, 16'h0, 16'h0, '0));
		dir_rows.push_back(tick_exp(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'hFFFF, '0));
		dir_rows.push_back(tick_exp(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0001, '0));
		dir_rows.push_back(tick_exp(32'd7, 32'h0, 16'd9, 16'h0, '0));
		dir_rows.push_back(tick_exp(32'd7, 32'h0, 16'hFFF6, 16'h0, '0));
		dir_rows.push_back(tick_exp(32'd7, 32'h0, 16'h0, 16'h0, '0));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_STALL_TICK_LIM, 16'h0));
		// jam with retreat below zero, arrival, finish with reload
		dir_rows.push_back(tick_exp(32'd100, 32'h0, 16'h0, 16'h0,
		                            '{1'b1, 32'hFFFF_FFDE, 1'b1, 1'b0, 16'h0}));
		dir_rows.push_back(tick_exp(32'h0, 32'hFFFF_FFDE, 16'h0, 16'h0,
		                            '{1'b1, 32'hFFFF_FFDE, 1'b1, 1'b0, 16'h0}));
		dir_rows.push_back(tick_exp(32'h0, 32'h0, 16'h0, 16'h1234,
		                            '{1'b0, 32'h0, 1'b0, 1'b1, 16'h1234}));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_RETREAT_DIST, 16'hFFFF));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_ARRIVAL_TOL, 16'h0));
		// retreat target wraps past the negative end; zero tolerance never arrives
		dir_rows.push_back(tick_exp(32'h0, 32'h8000_0000, 16'h0, 16'h0,
		                            '{1'b1, 32'h7FFF_0001, 1'b1, 1'b0, 16'h0}));
		dir_rows.push_back(tick_exp(32'h0, 32'h7FFF_0001, 16'h0, 16'h0,
		                            '{1'b1, 32'h7FFF_0001, 1'b1, 1'b0, 16'h0}));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_ARRIVAL_TOL, 16'hFFFF));
		dir_rows.push_back(tick_exp(32'h0, 32'h7FFF_FFFF, 16'h0, 16'h0,
		                            '{1'b1, 32'h7FFF_0001, 1'b1, 1'b0, 16'h0}));
		dir_rows.push_back(tick_exp(32'h0, 32'h0, 16'h0, 16'hFFFF,
		                            '{1'b0, 32'h0, 1'b0, 1'b1, 16'hFFFF}));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_POS_ERR_LIMIT, 16'hFFFF));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_STALL_SPD_LIMIT, 16'h0));
		// zero speed limit: nothing counts as stopped
		dir_rows.push_back(tick_exp(32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0, '0));
		dir_rows.push_back(cfg_row(fjdr_pkg::REG_STALL_SPD_LIMIT, 16'h7FFF));
		dir_rows.push_back(tick_exp(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h0, '0));
		dir_rows.push_back(tick_exp(32'h7FFF_FFFF, 32'h8000_0000, 16'h8001, 16'h0, '0));
		dir_rows.push_back(tick_row(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFE, 16'h0005));
		dir_rows.push_back(tick_row(32'h0, 32'h0001_0000, 16'h0, 16'h0));
		dir_rows.push_back(tick_row(32'h0, 32'h8000_0000, 16'h0, 16'h0));
		dir_rows.push_back(tick_row(32'd5, 32'h7FFF_0001, 16'h8000, 16'h0007));
		dir_rows.push_back(tick_row(32'h0, 32'h0, 16'h0, 16'hABCD));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
				if (i + 1 == dir_rows.size() || dir_rows[i + 1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_tick(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		// Random phases: all-zero and all-ones settings first, then mixed
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				c = '0;
			end else if (p == 1) begin
				c = '1;
			end else begin
				c.position_error_limit = $urandom_range(0, 3) == 0 ? 16'($urandom) :
				                         16'($urandom_range(0, 40));
				c.stall_speed_limit = $urandom_range(0, 3) == 0 ? 15'($urandom) :
				                      15'($urandom_range(1, 200));
				c.stall_tick_limit = 16'($urandom_range(0, 6));
				c.retreat_distance = 16'($urandom);
				c.arrival_tolerance = $urandom_range(0, 3) == 0 ? 16'($urandom) :
				                      16'($urandom_range(1, 64));
			end
			set_regs(c);
			repeat (TICKS_PER_PHASE) begin
				it = gen_tick();
				send_tick(it, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
